[rtl/assert_macros.svh]
// Assertion macros shared by the matrix unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define MAS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/mas_pkg.sv]
// Package for the matrix add/subtract/multiply unit: widths, codes,
// transaction structs and the microcode ROM. No dependencies.
package mas_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_BITS   = 16;
    localparam int RES_W       = 35;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int CMP_W       = DIM_W + 1;
    localparam int OP_W        = 2;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]            command;
        logic signed [ELEM_BITS-1:0] element;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic [POS_W-1:0]        result_row;
        logic [POS_W-1:0]        result_col;
        logic                    last;
        logic                    shape_error;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_CHECK = 4'd1,
        S_ELEM  = 4'd2,
        S_READ  = 4'd3,
        S_MUL   = 4'd4,
        S_ACC   = 4'd5,
        S_EMIT  = 4'd6,
        S_DONE  = 4'd7,
        S_ADD   = 4'd8,
        S_ERR   = 4'd9
    } t_step;

    typedef enum logic [3:0] {
        U_IDLE,
        U_INIT,
        U_ELEM,
        U_READ,
        U_MUL,
        U_ACC,
        U_EMIT,
        U_DONE,
        U_ADD,
        U_ERR
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_COMPUTE,
        C_SHAPE_ERR,
        C_ADDSUB,
        C_MAC_MORE,
        C_ELEM_MORE
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  wait_out;
        t_uop  uop;
        t_cond cond;
        t_step target;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_IDLE:  w = '{1'b1, 1'b0, U_IDLE, C_NO_COMPUTE, S_IDLE};
            S_CHECK: w = '{1'b0, 1'b0, U_INIT, C_SHAPE_ERR,  S_ERR};
            S_ELEM:  w = '{1'b0, 1'b0, U_ELEM, C_NEVER,      S_IDLE};
            S_READ:  w = '{1'b0, 1'b0, U_READ, C_ADDSUB,     S_ADD};
            S_MUL:   w = '{1'b0, 1'b0, U_MUL,  C_NEVER,      S_IDLE};
            S_ACC:   w = '{1'b0, 1'b0, U_ACC,  C_MAC_MORE,   S_READ};
            S_EMIT:  w = '{1'b0, 1'b1, U_EMIT, C_ELEM_MORE,  S_ELEM};
            S_DONE:  w = '{1'b0, 1'b0, U_DONE, C_ALWAYS,     S_IDLE};
            S_ADD:   w = '{1'b0, 1'b0, U_ADD,  C_ALWAYS,     S_EMIT};
            S_ERR:   w = '{1'b0, 1'b1, U_ERR,  C_ALWAYS,     S_DONE};
            default: w = '{1'b0, 1'b0, U_DONE, C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/mas_ram.sv]
// Generic simple dual-port RAM with registered read.
// Default sizes from mas_pkg.
module mas_ram #(
    parameter int WIDTH = mas_pkg::ELEM_BITS,
    parameter int DEPTH = mas_pkg::MAX_DIM_DEF * mas_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/matrix_add_sub_multiply_top.sv]
// A load is taken in the idle step. Compute checks shapes, then per result element reads
// both stores and adds/subtracts, or for multiply reads, multiplies and accumulates cols_a
// times (one shared multiply-accumulate unit, one read port per store), then emits; a shape
// error emits an error result. Output stalls hold emits. One transaction at a time.
// Reset: shapes 1x1, operation add, load counts zero; store contents are not cleared.
// Depends on mas_pkg, mas_ram and assert_macros.svh.
`include "assert_macros.svh"

module matrix_add_sub_multiply_top #(
    parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mas_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mas_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mas_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * mas_pkg::ELEM_BITS;
    localparam int DIM_W  = mas_pkg::DIM_W;
    localparam int CMP_W  = mas_pkg::CMP_W;
    localparam int RES_W  = mas_pkg::RES_W;
    localparam int POS_W  = mas_pkg::POS_W;

    logic [DIM_W-1:0]         r_rows_a;
    logic [DIM_W-1:0]         r_cols_a;
    logic [DIM_W-1:0]         r_rows_b;
    logic [DIM_W-1:0]         r_cols_b;
    logic [mas_pkg::OP_W-1:0] r_op;

    mas_pkg::t_step  r_step;
    mas_pkg::t_step  n_step;
    mas_pkg::t_uword w_uword;

    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;
    logic [IDX_W-1:0]  r_r;
    logic [IDX_W-1:0]  r_c;
    logic [IDX_W-1:0]  r_i;
    logic [ADDR_W-1:0] r_rowbase;
    logic [ADDR_W-1:0] r_ia;
    logic [ADDR_W-1:0] r_ib;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [RES_W-1:0]  r_acc;
    mas_pkg::t_out            r_out;
    logic                     r_out_valid;

    logic signed [mas_pkg::ELEM_BITS-1:0] w_rd_a;
    logic signed [mas_pkg::ELEM_BITS-1:0] w_rd_b;

    logic             w_out_busy;
    logic             w_hold;
    logic             w_in_fire;
    logic             w_compute;
    logic             w_we_a;
    logic             w_we_b;
    logic             w_re;
    logic             w_is_mul;
    logic             w_shape_ok;
    logic [DIM_W-1:0] w_nc;
    logic             w_mac_more;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_elem_more;
    logic             w_take;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (CMP_W'(d) <= CMP_W'(MAX_DIM));
    endfunction

    assign w_uword    = mas_pkg::ucode(r_step);
    assign w_out_busy = r_out_valid & i_out_stall;
    assign w_hold     = w_uword.wait_out & w_out_busy;
    assign w_in_fire  = i_in_valid & w_uword.accept;
    assign w_compute  = w_in_fire && (i_in.command == mas_pkg::CMD_COMPUTE);
    assign w_we_a     = w_in_fire && (i_in.command == mas_pkg::CMD_LOAD_A)
                        && (r_cnt_a < CNT_W'(DEPTH));
    assign w_we_b     = w_in_fire && (i_in.command == mas_pkg::CMD_LOAD_B)
                        && (r_cnt_b < CNT_W'(DEPTH));
    assign w_re       = (w_uword.uop == mas_pkg::U_READ);

    assign w_is_mul = (r_op == mas_pkg::OP_MUL);

    always_comb begin
        w_shape_ok = dim_ok(r_rows_a) && dim_ok(r_cols_a)
                     && dim_ok(r_rows_b) && dim_ok(r_cols_b);
        if ((r_op == mas_pkg::OP_ADD) || (r_op == mas_pkg::OP_SUB)) begin
            w_shape_ok = w_shape_ok && (r_rows_a == r_rows_b) && (r_cols_a == r_cols_b);
        end else if (w_is_mul) begin
            w_shape_ok = w_shape_ok && (r_cols_a == r_rows_b);
        end else begin
            w_shape_ok = 1'b0;
        end
    end

    assign w_nc        = w_is_mul ? r_cols_b : r_cols_a;
    assign w_mac_more  = (CMP_W'(r_i) + CMP_W'(1)) != CMP_W'(r_cols_a);
    assign w_col_last  = (CMP_W'(r_c) + CMP_W'(1)) == CMP_W'(w_nc);
    assign w_row_last  = (CMP_W'(r_r) + CMP_W'(1)) == CMP_W'(r_rows_a);
    assign w_elem_more = !(w_col_last && w_row_last);

    always_comb begin
        unique case (w_uword.cond)
            mas_pkg::C_NEVER:      w_take = 1'b0;
            mas_pkg::C_ALWAYS:     w_take = 1'b1;
            mas_pkg::C_NO_COMPUTE: w_take = !w_compute;
            mas_pkg::C_SHAPE_ERR:  w_take = !w_shape_ok;
            mas_pkg::C_ADDSUB:     w_take = !w_is_mul;
            mas_pkg::C_MAC_MORE:   w_take = w_mac_more;
            mas_pkg::C_ELEM_MORE:  w_take = w_elem_more;
            default:               w_take = 1'b1;
        endcase
        if (w_hold) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uword.target;
        end else begin
            n_step = mas_pkg::t_step'(4'(r_step) + 4'd1);
        end
    end

    mas_ram #(
        .WIDTH (mas_pkg::ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[ADDR_W-1:0]),
        .i_wdata (i_in.element),
        .i_re    (w_re),
        .i_raddr (r_ia),
        .o_rdata (w_rd_a)
    );

    mas_ram #(
        .WIDTH (mas_pkg::ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[ADDR_W-1:0]),
        .i_wdata (i_in.element),
        .i_re    (w_re),
        .i_raddr (r_ib),
        .o_rdata (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(1);
            r_cols_a    <= DIM_W'(1);
            r_rows_b    <= DIM_W'(1);
            r_cols_b    <= DIM_W'(1);
            r_op        <= mas_pkg::OP_ADD;
            r_step      <= mas_pkg::S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mas_pkg::CFG_ROWS_A:    r_rows_a <= i_cfg_data;
                    mas_pkg::CFG_COLS_A:    r_cols_a <= i_cfg_data;
                    mas_pkg::CFG_ROWS_B:    r_rows_b <= i_cfg_data;
                    mas_pkg::CFG_COLS_B:    r_cols_b <= i_cfg_data;
                    mas_pkg::CFG_OPERATION: r_op     <= i_cfg_data[mas_pkg::OP_W-1:0];
                    default: ;
                endcase
            end
            if (w_we_a) begin
                r_cnt_a <= r_cnt_a + CNT_W'(1);
            end
            if (w_we_b) begin
                r_cnt_b <= r_cnt_b + CNT_W'(1);
            end
            if (w_uword.uop == mas_pkg::U_DONE) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end
            if (!w_hold && ((w_uword.uop == mas_pkg::U_EMIT)
                            || (w_uword.uop == mas_pkg::U_ERR))) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            unique case (w_uword.uop)
                mas_pkg::U_INIT: begin
                    r_r       <= '0;
                    r_c       <= '0;
                    r_rowbase <= '0;
                end
                mas_pkg::U_ELEM: begin
                    r_i   <= '0;
                    r_acc <= '0;
                    if (w_is_mul) begin
                        r_ia <= r_rowbase;
                        r_ib <= ADDR_W'(r_c);
                    end else begin
                        r_ia <= r_rowbase + ADDR_W'(r_c);
                        r_ib <= r_rowbase + ADDR_W'(r_c);
                    end
                end
                mas_pkg::U_MUL: begin
                    r_prod <= w_rd_a * w_rd_b;
                end
                mas_pkg::U_ACC: begin
                    r_acc <= r_acc + RES_W'(r_prod);
                    r_i   <= r_i + IDX_W'(1);
                    r_ia  <= r_ia + ADDR_W'(1);
                    r_ib  <= r_ib + ADDR_W'(r_cols_b);
                end
                mas_pkg::U_ADD: begin
                    if (r_op == mas_pkg::OP_SUB) begin
                        r_acc <= RES_W'(w_rd_a) - RES_W'(w_rd_b);
                    end else begin
                        r_acc <= RES_W'(w_rd_a) + RES_W'(w_rd_b);
                    end
                end
                mas_pkg::U_EMIT: begin
                    r_out.result_value <= r_acc;
                    r_out.result_row   <= POS_W'(r_r);
                    r_out.result_col   <= POS_W'(r_c);
                    r_out.last         <= !w_elem_more;
                    r_out.shape_error  <= 1'b0;
                    if (w_col_last) begin
                        r_c       <= '0;
                        r_r       <= r_r + IDX_W'(1);
                        r_rowbase <= r_rowbase + ADDR_W'(r_cols_a);
                    end else begin
                        r_c <= r_c + IDX_W'(1);
                    end
                end
                mas_pkg::U_ERR: begin
                    r_out.result_value <= '0;
                    r_out.result_row   <= '0;
                    r_out.result_col   <= '0;
                    r_out.last         <= 1'b1;
                    r_out.shape_error  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = !w_uword.accept;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    `MAS_ASSERT_NEVER(a_cnt_a_range, i_clk, i_rst_n, r_cnt_a > CNT_W'(DEPTH),
                      "load count A past depth")
    `MAS_ASSERT_NEVER(a_cnt_b_range, i_clk, i_rst_n, r_cnt_b > CNT_W'(DEPTH),
                      "load count B past depth")
    `MAS_ASSERT(a_err_last, i_clk, i_rst_n,
                r_out_valid && r_out.shape_error |-> r_out.last,
                "error transaction not last")
    `MAS_ASSERT(a_done_clear, i_clk, i_rst_n,
                (r_step == mas_pkg::S_DONE) |=> (r_cnt_a == '0) && (r_cnt_b == '0)
                && (r_step == mas_pkg::S_IDLE),
                "run end did not clear counts")

endmodule
